// File: hw/rtl/bbc_pkg.sv
package bbc_pkg;

  localparam int NUM_ENTRIES = 64;
  localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int SLOT_W      = 6;
  localparam int CMP_W       = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

  localparam logic [7:0] REF_MAX = 8'hFF;

  localparam logic CMD_ACQUIRE = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_UNHELD  = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_HIT,
    OP_FILL,
    OP_REL
  } commit_op_e;

  // request record that walks the row of cells, gathering the lookup outcome
  typedef struct packed {
    logic              valid;
    logic              cmd;
    logic [7:0]        dev;
    logic [31:0]       blk;
    logic [SLOT_W-1:0] rel;
    logic [31:0]       tick;
    logic              hit_found;
    logic [IDX_W-1:0]  hit_idx;
    logic              hit_cv;
    logic              vic_found;
    logic [IDX_W-1:0]  vic_idx;
    logic [31:0]       vic_stamp;
    logic              rel_held;
  } sweep_t;

  // update broadcast to all cells once the walk is over
  typedef struct packed {
    commit_op_e       op;
    logic [IDX_W-1:0] idx;
    logic [7:0]       dev;
    logic [31:0]      blk;
    logic [31:0]      tick;
  } commit_t;

endpackage

// File: hw/rtl/bbc_cell.sv
module bbc_cell import bbc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] cell_idx_i,
  input  sweep_t           rec_i,
  input  commit_t          cmt_i,
  output sweep_t           rec_o
);

  logic [7:0]  tag_dev_q;
  logic [31:0] tag_blk_q;
  logic        occ_q, occ_d;
  logic        cv_q, cv_d;
  logic [7:0]  ref_q, ref_d;
  logic [31:0] last_q, last_d;
  sweep_t      rec_q, rec_d;
  logic        match;
  logic        sel;

  // fold this entry into the passing record
  always_comb begin
    rec_d = rec_i;
    match = occ_q && (tag_dev_q == rec_i.dev) && (tag_blk_q == rec_i.blk);
    if (rec_i.cmd == CMD_ACQUIRE) begin
      if (!rec_i.hit_found && match) begin
        rec_d.hit_found = 1'b1;
        rec_d.hit_idx   = cell_idx_i;
        rec_d.hit_cv    = cv_q;
      end
      if ((ref_q == 8'd0) && (!rec_i.vic_found || (last_q < rec_i.vic_stamp))) begin
        rec_d.vic_found = 1'b1;
        rec_d.vic_idx   = cell_idx_i;
        rec_d.vic_stamp = last_q;
      end
    end else if (CMP_W'(rec_i.rel) == CMP_W'(cell_idx_i)) begin
      rec_d.rel_held = (ref_q != 8'd0);
    end
  end

  // apply the broadcast update when it names this entry
  always_comb begin
    occ_d  = occ_q;
    cv_d   = cv_q;
    ref_d  = ref_q;
    last_d = last_q;
    sel    = (cmt_i.op != OP_NONE) && (cmt_i.idx == cell_idx_i);
    if (sel) begin
      case (cmt_i.op)
        OP_HIT: begin
          if (ref_q != REF_MAX) ref_d = ref_q + 8'd1;
          last_d = cmt_i.tick;
          cv_d   = 1'b1;
        end
        OP_FILL: begin
          occ_d  = 1'b1;
          ref_d  = 8'd1;
          last_d = cmt_i.tick;
          cv_d   = 1'b1;
        end
        OP_REL: begin
          ref_d = ref_q - 8'd1;
        end
        default: begin
          ref_d = ref_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= 1'b0;
      cv_q   <= 1'b0;
      ref_q  <= 8'd0;
      last_q <= 32'd0;
      rec_q  <= '0;
    end else begin
      occ_q  <= occ_d;
      cv_q   <= cv_d;
      ref_q  <= ref_d;
      last_q <= last_d;
      rec_q  <= rec_d;
    end
  end

  // tags are only read behind occupied
  always_ff @(posedge clk_i) begin
    if (sel && (cmt_i.op == OP_FILL)) begin
      tag_dev_q <= cmt_i.dev;
      tag_blk_q <= cmt_i.blk;
    end
  end

  assign rec_o = rec_q;

endmodule

// File: hw/rtl/block_buffer_cache_lru.sv
// channel  dir  handshake                      payload
// s_axis   in   s_axis_tvalid / s_axis_tready  tuser: cmd; tdata: device, block, slot, tick
// m_axis   out  m_axis_tvalid / m_axis_tready  tdata: slot, hit, needs_fill, status
//
// each word walks the row of NUM_ENTRIES cells, one cell a cycle, and its result is
// then registered in the output register; a new word is taken only once the sequencer
// is back in idle, never while a word is in the row
// reset clears all counts, stamps, occupied and valid flags at once; no clearing pass
// a stalled output holds the finished word; the next result waits in a hold register
// and no new word is taken until it has moved to the output
module block_buffer_cache_lru import bbc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [0:0]  s_axis_tuser,  // [0] cmd
  input  logic [79:0] s_axis_tdata,  // [7:0] device, [39:8] block_number,
                                     // [45:40] slot_in, [77:46] now_tick, [79:78] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // [5:0] slot, [6] hit, [7] needs_fill,
                                     // [9:8] status, [15:10] zero
);

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              hit;
    logic              fill;
    logic [1:0]        status;
  } result_t;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SWEEP = 2'd1;
  localparam logic [1:0] S_HOLD  = 2'd2;

  logic [1:0]       state_q, state_d;
  sweep_t           launch;
  sweep_t           link [NUM_ENTRIES+1];
  logic [NUM_ENTRIES-1:0] link_valid;
  sweep_t           last_rec;
  commit_t          cmt;
  result_t          res_now;
  result_t          hold_q, hold_d;
  result_t          out_q, out_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;
  logic             done;
  logic             out_free;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // launch record into the first cell
  always_comb begin
    launch        = '0;
    launch.valid  = accept;
    launch.cmd    = s_axis_tuser[0];
    launch.dev    = s_axis_tdata[7:0];
    launch.blk    = s_axis_tdata[39:8];
    launch.rel    = s_axis_tdata[45:40];
    launch.tick   = s_axis_tdata[77:46];
  end

  assign link[0] = launch;

  for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_cell
    bbc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(i)),
      .rec_i      (link[i]),
      .cmt_i      (cmt),
      .rec_o      (link[i+1])
    );
    assign link_valid[i] = link[i+1].valid;
  end

  assign last_rec = link[NUM_ENTRIES];
  assign done     = last_rec.valid && (state_q == S_SWEEP);

  // decide the outcome when the record leaves the last cell
  always_comb begin
    res_now  = '0;
    cmt      = '0;
    cmt.op   = OP_NONE;
    cmt.dev  = last_rec.dev;
    cmt.blk  = last_rec.blk;
    cmt.tick = last_rec.tick;
    if (last_rec.cmd == CMD_RELEASE) begin
      res_now.slot = last_rec.rel;
      if (last_rec.rel_held) begin
        res_now.status = ST_OK;
        cmt.op         = OP_REL;
        cmt.idx        = IDX_W'(CMP_W'(last_rec.rel));
      end else begin
        res_now.status = ST_UNHELD;
      end
    end else if (last_rec.hit_found) begin
      res_now.slot   = SLOT_W'(CMP_W'(last_rec.hit_idx));
      res_now.hit    = 1'b1;
      res_now.fill   = !last_rec.hit_cv;
      res_now.status = ST_OK;
      cmt.op         = OP_HIT;
      cmt.idx        = last_rec.hit_idx;
    end else if (last_rec.vic_found) begin
      res_now.slot   = SLOT_W'(CMP_W'(last_rec.vic_idx));
      res_now.fill   = 1'b1;
      res_now.status = ST_OK;
      cmt.op         = OP_FILL;
      cmt.idx        = last_rec.vic_idx;
    end else begin
      res_now.status = ST_NO_FREE;
    end
    if (!done) cmt.op = OP_NONE;
  end

  assign out_free = !out_valid_q || m_axis_tready;

  // sequencer and output register
  always_comb begin
    state_d     = state_q;
    hold_d      = hold_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_SWEEP;
      end
      S_SWEEP: begin
        if (done) begin
          if (out_free) begin
            out_d       = res_now;
            out_valid_d = 1'b1;
            state_d     = S_IDLE;
          end else begin
            hold_d  = res_now;
            state_d = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_d       = hold_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    out_q  <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q.status, out_q.fill, out_q.hit, out_q.slot};

  // only one request may be in the row at a time
  a_single_walker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(link_valid))
    else $error("more than one request in the cell row");

  // an accepted word always starts a walk
  a_accept_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_SWEEP) && link_valid[0])
    else $error("accepted word did not enter the cell row");

  // a record never leaves the row outside a walk
  a_exit_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_rec.valid |-> (state_q == S_SWEEP))
    else $error("record left the row while not walking");

  // only defined status codes reach the output
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[9:8] == ST_OK) || (m_axis_tdata[9:8] == ST_NO_FREE) ||
                       (m_axis_tdata[9:8] == ST_UNHELD)))
    else $error("reserved status code on output");

endmodule
